@@ hw/rtl/pidl_pkg.sv @@
package pidl_pkg;

	// list capacity
	localparam int DEPTH = 32;

	// field widths of the words on the two channels
	localparam int CMD_W    = 2;
	localparam int POS_W    = 6;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 6;
	localparam int COUNT_W  = 6;

	// internal widths
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1) + 1;
	localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	// decoupling queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

	// command codes on the input channel
	localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TRAVERSE = 2'd2;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_DELETE,
		OP_TRAVERSE,
		OP_BAD
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK     = 2'd0,
		STATUS_FULL   = 2'd1,
		STATUS_EMPTY  = 2'd2,
		STATUS_BADPOS = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	typedef struct packed {
		op_t                        op;
		logic [POS_W-1:0]           position;
		logic signed [VALUE_W-1:0]  value;
	} item_t;

endpackage

@@ hw/rtl/positional_insert_delete_list_top.sv @@
// Ordered list of up to 32 signed 32-bit entries with insert, delete and traverse
// commands on a valid/ready input channel and one or more result words on a
// valid/ready output channel; every command ends with a word that has last set.
// A front stage decodes each command into a two-slot queue, and the back end
// executes it against the list held in registers: insert and delete move all
// later entries at once, in parallel, and the sustained rate is one command per
// clock while the output is not stalled. A traversal occupies the back end for a
// dispatch step and then one step per emitted entry, each through the single
// output register. A command word is registered in the front stage and in the
// queue slot before its result word is registered at the output. After reset the
// list is empty and usable at once.
module positional_insert_delete_list_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [pidl_pkg::CMD_W-1:0]             command,
	input  logic [pidl_pkg::POS_W-1:0]             position,
	input  logic signed [pidl_pkg::VALUE_W-1:0]    value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [pidl_pkg::STATUS_W-1:0]          status,
	output logic signed [pidl_pkg::VALUE_W-1:0]    data,
	output logic [pidl_pkg::INDEX_W-1:0]           index,
	output logic [pidl_pkg::COUNT_W-1:0]           count_after,
	output logic                                   last
);

	logic            push_valid;
	logic            push_ready;
	pidl_pkg::item_t push_item;
	logic            q_valid;
	logic            q_pop;
	pidl_pkg::item_t q_item;

	// decode stage
	pidl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.position   (position),
		.value      (value),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// command queue
	pidl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_item   (q_item)
	);

	// list storage and execution
	pidl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.data        (data),
		.index       (index),
		.count_after (count_after),
		.last        (last)
	);

endmodule

@@ hw/rtl/pidl_front.sv @@
module pidl_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [pidl_pkg::CMD_W-1:0]           command,
	input  logic [pidl_pkg::POS_W-1:0]           position,
	input  logic signed [pidl_pkg::VALUE_W-1:0]  value,
	output logic                                 push_valid,
	input  logic                                 push_ready,
	output pidl_pkg::item_t                      push_item
);

	logic            valid_s1;
	pidl_pkg::item_t item_s1;
	pidl_pkg::op_t   op_dec;

	// command decode
	always_comb begin
		unique case (command)
			pidl_pkg::CMD_INSERT:   op_dec = pidl_pkg::OP_INSERT;
			pidl_pkg::CMD_DELETE:   op_dec = pidl_pkg::OP_DELETE;
			pidl_pkg::CMD_TRAVERSE: op_dec = pidl_pkg::OP_TRAVERSE;
			default:                op_dec = pidl_pkg::OP_BAD;
		endcase
	end

	assign in_ready = !valid_s1 || push_ready;

	// front stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// front stage word
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.op       <= op_dec;
			item_s1.position <= position;
			item_s1.value    <= value;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

@@ hw/rtl/pidl_queue.sv @@
module pidl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  pidl_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop,
	output pidl_pkg::item_t pop_item
);

	pidl_pkg::item_t                 slot_q [pidl_pkg::QUEUE_DEPTH];
	logic [pidl_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [pidl_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [pidl_pkg::QFILL_W-1:0]    fill_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = fill_q != pidl_pkg::QFILL_W'(pidl_pkg::QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == pidl_pkg::QPTR_W'(pidl_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + pidl_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == pidl_pkg::QPTR_W'(pidl_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + pidl_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + pidl_pkg::QFILL_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - pidl_pkg::QFILL_W'(1);
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ hw/rtl/pidl_back.sv @@
module pidl_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   q_valid,
	input  pidl_pkg::item_t                        q_item,
	output logic                                   q_pop,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [pidl_pkg::STATUS_W-1:0]          status,
	output logic signed [pidl_pkg::VALUE_W-1:0]    data,
	output logic [pidl_pkg::INDEX_W-1:0]           index,
	output logic [pidl_pkg::COUNT_W-1:0]           count_after,
	output logic                                   last
);

	pidl_pkg::state_t                      state_q;
	pidl_pkg::state_t                      state_d;
	logic [pidl_pkg::ADDR_W-1:0]           walk_idx_q;
	logic [pidl_pkg::CNT_W-1:0]            count_q;
	logic [pidl_pkg::CNT_W-1:0]            count_d;
	logic signed [pidl_pkg::VALUE_W-1:0]   cell_q [pidl_pkg::DEPTH];
	logic signed [pidl_pkg::VALUE_W-1:0]   cell_d [pidl_pkg::DEPTH];

	logic                                  out_valid_q;
	pidl_pkg::status_t                     status_q;
	logic signed [pidl_pkg::VALUE_W-1:0]   data_q;
	logic [pidl_pkg::INDEX_W-1:0]          index_q;
	logic [pidl_pkg::COUNT_W-1:0]          count_after_q;
	logic                                  last_q;

	logic                                  out_free;
	logic [pidl_pkg::CMP_W-1:0]            pos_ext;
	logic [pidl_pkg::CMP_W-1:0]            pos_m1;
	logic [pidl_pkg::CMP_W-1:0]            cnt_ext;
	logic                                  ins_full;
	logic                                  ins_bad;
	logic                                  del_empty;
	logic                                  del_bad;
	logic [pidl_pkg::CNT_W-1:0]            walk_pos;
	logic                                  walk_last;

	logic                                  emit;
	logic                                  do_ins;
	logic                                  do_del;
	logic                                  walk_start;
	logic                                  walk_step;
	pidl_pkg::status_t                     res_status;
	logic signed [pidl_pkg::VALUE_W-1:0]   res_data;
	logic [pidl_pkg::INDEX_W-1:0]          res_index;
	logic                                  res_last;

	// range checks against the current count
	assign out_free  = !out_valid_q || out_ready;
	assign pos_ext   = pidl_pkg::CMP_W'(q_item.position);
	assign pos_m1    = pos_ext - pidl_pkg::CMP_W'(1);
	assign cnt_ext   = pidl_pkg::CMP_W'(count_q);
	assign ins_full  = count_q == pidl_pkg::CNT_W'(pidl_pkg::DEPTH);
	assign ins_bad   = (pos_ext == '0) || (pos_ext > cnt_ext + pidl_pkg::CMP_W'(1));
	assign del_empty = count_q == '0;
	assign del_bad   = (pos_ext == '0) || (pos_ext > cnt_ext);
	assign walk_pos  = pidl_pkg::CNT_W'(walk_idx_q) + pidl_pkg::CNT_W'(1);
	assign walk_last = walk_pos == count_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pidl_pkg::ST_IDLE: begin
				if (q_valid && out_free && q_item.op == pidl_pkg::OP_TRAVERSE && !del_empty) begin
					state_d = pidl_pkg::ST_WALK;
				end
			end
			pidl_pkg::ST_WALK: begin
				if (out_free && walk_last) begin
					state_d = pidl_pkg::ST_IDLE;
				end
			end
			default: state_d = pidl_pkg::ST_IDLE;
		endcase
	end

	// command execution and result word
	always_comb begin
		q_pop      = 1'b0;
		emit       = 1'b0;
		do_ins     = 1'b0;
		do_del     = 1'b0;
		walk_start = 1'b0;
		walk_step  = 1'b0;
		count_d    = count_q;
		res_status = pidl_pkg::STATUS_OK;
		res_data   = '0;
		res_index  = '0;
		res_last   = 1'b1;
		unique case (state_q)
			pidl_pkg::ST_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					emit  = 1'b1;
					unique case (q_item.op)
						pidl_pkg::OP_INSERT: begin
							if (ins_full) begin
								res_status = pidl_pkg::STATUS_FULL;
							end else if (ins_bad) begin
								res_status = pidl_pkg::STATUS_BADPOS;
							end else begin
								do_ins  = 1'b1;
								count_d = count_q + pidl_pkg::CNT_W'(1);
							end
						end
						pidl_pkg::OP_DELETE: begin
							if (del_empty) begin
								res_status = pidl_pkg::STATUS_EMPTY;
							end else if (del_bad) begin
								res_status = pidl_pkg::STATUS_BADPOS;
							end else begin
								do_del  = 1'b1;
								count_d = count_q - pidl_pkg::CNT_W'(1);
							end
						end
						pidl_pkg::OP_TRAVERSE: begin
							if (del_empty) begin
								res_status = pidl_pkg::STATUS_EMPTY;
							end else begin
								emit       = 1'b0;
								walk_start = 1'b1;
							end
						end
						default: res_status = pidl_pkg::STATUS_BADPOS;
					endcase
				end
			end
			pidl_pkg::ST_WALK: begin
				if (out_free) begin
					emit      = 1'b1;
					walk_step = 1'b1;
					res_data  = cell_q[walk_idx_q];
					res_index = pidl_pkg::INDEX_W'(walk_pos);
					res_last  = walk_last;
				end
			end
			default: ;
		endcase
	end

	// parallel shift of all cells
	always_comb begin
		for (int i = 0; i < pidl_pkg::DEPTH; i++) begin
			cell_d[i] = cell_q[i];
		end
		if (do_ins) begin
			for (int i = 1; i < pidl_pkg::DEPTH; i++) begin
				if (pidl_pkg::CMP_W'(i) > pos_m1) begin
					cell_d[i] = cell_q[i-1];
				end
			end
			for (int i = 0; i < pidl_pkg::DEPTH; i++) begin
				if (pidl_pkg::CMP_W'(i) == pos_m1) begin
					cell_d[i] = q_item.value;
				end
			end
		end else if (do_del) begin
			for (int i = 0; i < pidl_pkg::DEPTH - 1; i++) begin
				if (pidl_pkg::CMP_W'(i) >= pos_m1) begin
					cell_d[i] = cell_q[i+1];
				end
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pidl_pkg::ST_IDLE;
			count_q     <= '0;
			walk_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (walk_start) begin
				walk_idx_q <= '0;
			end else if (walk_step && !walk_last) begin
				walk_idx_q <= walk_idx_q + pidl_pkg::ADDR_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// cells and output word
	always_ff @(posedge clk) begin
		for (int i = 0; i < pidl_pkg::DEPTH; i++) begin
			cell_q[i] <= cell_d[i];
		end
		if (emit) begin
			status_q      <= res_status;
			data_q        <= res_data;
			index_q       <= res_index;
			count_after_q <= pidl_pkg::COUNT_W'(count_d);
			last_q        <= res_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign data        = data_q;
	assign index       = index_q;
	assign count_after = count_after_q;
	assign last        = last_q;

	// the list never holds more than its capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pidl_pkg::CNT_W'(pidl_pkg::DEPTH))
		else $error("entry count above capacity");

	// a traversal only visits held entries
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pidl_pkg::ST_WALK |-> walk_pos <= count_q)
		else $error("traversal index beyond count");

	// the list is left alone while a result word is stalled
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(count_q))
		else $error("count changed under a stalled word");

	// a traversal begins only on a non-empty list
	a_walk_entry: assert property (@(posedge clk) disable iff (!arst_n)
		walk_start |-> count_q != '0 && !emit)
		else $error("traversal started on an empty list");

endmodule
